// ===== rtl/rpdtp_pkg.sv =====
package rpdtp_pkg;

    localparam int DEF_MAX_WIDTH       = 256;
    localparam int DEF_MAX_HEIGHT      = 128;
    localparam int DEF_CAMERA_DISTANCE = 100;

    localparam int ACC_W    = 48;
    localparam int COEF_W   = 20;
    localparam int MUL_A_W  = 48;
    localparam int MUL_B_W  = 32;
    localparam int MUL_P_W  = 64;
    localparam int NUM_COEF = 9;
    localparam int KIDX_W   = 4;
    localparam int STEP_W   = 6;
    localparam int FRAC_SH  = 14;
    localparam int DIST_SH  = 18;

    localparam logic [STEP_W-1:0] STEP_Z_LAST = 6'd26;
    localparam logic [STEP_W-1:0] STEP_NY     = 6'd28;
    localparam logic [STEP_W-1:0] STEP_IDX    = 6'd29;
    localparam logic [STEP_W-1:0] STEP_LAST   = 6'd32;

    localparam logic [MUL_B_W-1:0] ONE_Q14 = 32'd16384;
    localparam logic [31:0]        KEY_MAX = 32'hFFFF_FFFF;
    localparam logic [31:0]        D2_SAT  = 32'hFFFF_FFFE;

    typedef enum logic [1:0] {
        KIND_PLOT  = 2'd0,
        KIND_CLEAR = 2'd1,
        KIND_READ  = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic signed [15:0] point_x;
        logic signed [15:0] point_y;
        logic signed [15:0] point_z;
        logic [7:0]         glyph;
        logic [14:0]        cell_address;
    } in_item_t;

    typedef struct packed {
        logic        written;
        logic        out_of_view;
        logic [14:0] hit_address;
        logic [7:0]  read_glyph;
    } out_item_t;

    typedef enum logic [2:0] {
        REG_ANGLE_A  = 3'd0,
        REG_ANGLE_B  = 3'd1,
        REG_ANGLE_C  = 3'd2,
        REG_CENTER_X = 3'd3,
        REG_CENTER_Y = 3'd4,
        REG_CENTER_Z = 3'd5,
        REG_SCREEN_W = 3'd6,
        REG_SCREEN_H = 3'd7
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_GO,
        ST_MUL_WAIT,
        ST_ZCHK,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_RANGE,
        ST_CELL,
        ST_MEM_RD,
        ST_MEM_CHK,
        ST_DONE
    } state_t;

    typedef enum logic [4:0] {
        A_SA, A_CA, A_SB, A_CB, A_SASB, A_CASB,
        A_DX, A_DY, A_DZ, A_CX, A_CY, A_CZ,
        A_XX, A_YY, A_ROW, A_QX, A_QY, A_QZ
    } src_a_t;

    typedef enum logic [3:0] {
        B_SB, B_CB, B_SC, B_CC, B_ONE, B_K, B_DIST, B_WIDTH, B_QX, B_QY, B_QZ
    } src_b_t;

    typedef enum logic [3:0] {
        DST_SASB, DST_CASB, DST_K, DST_XX, DST_YY, DST_ZZ,
        DST_NX, DST_NY, DST_IDX, DST_D2
    } dst_t;

    typedef enum logic [1:0] {
        MODE_SET,
        MODE_ADD,
        MODE_SUB
    } acc_mode_t;

    typedef struct packed {
        src_a_t             a;
        src_b_t             b;
        logic               shr14;
        dst_t               dst;
        logic [KIDX_W-1:0]  kidx;
        acc_mode_t          mode;
    } op_t;

    // multiply sequence: matrix entries, rotation, projection numerators,
    // cell index, squared distance
    function automatic op_t step_op(input logic [STEP_W-1:0] step);
        op_t op;
        case (step)
            6'd0:  op = '{A_SA,   B_SB,    1'b1, DST_SASB, 4'd0, MODE_SET};
            6'd1:  op = '{A_CA,   B_SB,    1'b1, DST_CASB, 4'd0, MODE_SET};
            6'd2:  op = '{A_CB,   B_CC,    1'b1, DST_K,    4'd0, MODE_SET};
            6'd3:  op = '{A_SASB, B_CC,    1'b1, DST_K,    4'd1, MODE_SET};
            6'd4:  op = '{A_CA,   B_SC,    1'b1, DST_K,    4'd1, MODE_ADD};
            6'd5:  op = '{A_SA,   B_SC,    1'b1, DST_K,    4'd2, MODE_SET};
            6'd6:  op = '{A_CASB, B_CC,    1'b1, DST_K,    4'd2, MODE_SUB};
            6'd7:  op = '{A_CB,   B_SC,    1'b1, DST_K,    4'd3, MODE_SET};
            6'd8:  op = '{A_CA,   B_CC,    1'b1, DST_K,    4'd4, MODE_SET};
            6'd9:  op = '{A_SASB, B_SC,    1'b1, DST_K,    4'd4, MODE_SUB};
            6'd10: op = '{A_SA,   B_CC,    1'b1, DST_K,    4'd5, MODE_SET};
            6'd11: op = '{A_CASB, B_SC,    1'b1, DST_K,    4'd5, MODE_ADD};
            6'd12: op = '{A_SB,   B_ONE,   1'b1, DST_K,    4'd6, MODE_SET};
            6'd13: op = '{A_SA,   B_CB,    1'b1, DST_K,    4'd7, MODE_SET};
            6'd14: op = '{A_CA,   B_CB,    1'b1, DST_K,    4'd8, MODE_SET};
            6'd15: op = '{A_CX,   B_ONE,   1'b0, DST_XX,   4'd0, MODE_SET};
            6'd16: op = '{A_DX,   B_K,     1'b0, DST_XX,   4'd0, MODE_ADD};
            6'd17: op = '{A_DY,   B_K,     1'b0, DST_XX,   4'd1, MODE_ADD};
            6'd18: op = '{A_DZ,   B_K,     1'b0, DST_XX,   4'd2, MODE_ADD};
            6'd19: op = '{A_CY,   B_ONE,   1'b0, DST_YY,   4'd0, MODE_SET};
            6'd20: op = '{A_DX,   B_K,     1'b0, DST_YY,   4'd3, MODE_SUB};
            6'd21: op = '{A_DY,   B_K,     1'b0, DST_YY,   4'd4, MODE_ADD};
            6'd22: op = '{A_DZ,   B_K,     1'b0, DST_YY,   4'd5, MODE_ADD};
            6'd23: op = '{A_CZ,   B_ONE,   1'b0, DST_ZZ,   4'd0, MODE_SET};
            6'd24: op = '{A_DX,   B_K,     1'b0, DST_ZZ,   4'd6, MODE_ADD};
            6'd25: op = '{A_DY,   B_K,     1'b0, DST_ZZ,   4'd7, MODE_SUB};
            6'd26: op = '{A_DZ,   B_K,     1'b0, DST_ZZ,   4'd8, MODE_ADD};
            6'd27: op = '{A_XX,   B_DIST,  1'b0, DST_NX,   4'd0, MODE_SET};
            6'd28: op = '{A_YY,   B_DIST,  1'b0, DST_NY,   4'd0, MODE_SET};
            6'd29: op = '{A_ROW,  B_WIDTH, 1'b0, DST_IDX,  4'd0, MODE_SET};
            6'd30: op = '{A_QX,   B_QX,    1'b0, DST_D2,   4'd0, MODE_SET};
            6'd31: op = '{A_QY,   B_QY,    1'b0, DST_D2,   4'd0, MODE_ADD};
            6'd32: op = '{A_QZ,   B_QZ,    1'b0, DST_D2,   4'd0, MODE_ADD};
            default: op = '{A_SA, B_SB,    1'b0, DST_D2,   4'd0, MODE_SET};
        endcase
        return op;
    endfunction

endpackage

// ===== rtl/rpdtp_mul.sv =====
module rpdtp_mul
    import rpdtp_pkg::*;
#(
    parameter int A_W = MUL_A_W,
    parameter int B_W = MUL_B_W,
    parameter int P_W = MUL_P_W
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic signed [A_W-1:0] a,
    input  logic signed [B_W-1:0] b,
    output logic                  done,
    output logic signed [P_W-1:0] product
);

    localparam int CNT_W = $clog2(B_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(B_W - 1);

    logic signed [P_W-1:0] acc_reg, acc_next;
    logic signed [P_W-1:0] a_sh_reg, a_sh_next;
    logic [B_W-1:0]        b_sh_reg, b_sh_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  run_reg, run_next;
    logic                  done_reg, done_next;
    logic signed [P_W-1:0] addend;

    always_comb begin
        acc_next  = acc_reg;
        a_sh_next = a_sh_reg;
        b_sh_next = b_sh_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        addend    = b_sh_reg[0] ? a_sh_reg : '0;
        if (start) begin
            acc_next  = '0;
            a_sh_next = P_W'(a);
            b_sh_next = b;
            cnt_next  = '0;
            run_next  = 1'b1;
        end else if (run_reg) begin
            // top bit of b carries negative weight
            if (cnt_reg == CNT_LAST) begin
                acc_next  = acc_reg - addend;
                run_next  = 1'b0;
                done_next = 1'b1;
            end else begin
                acc_next = acc_reg + addend;
            end
            a_sh_next = a_sh_reg <<< 1;
            b_sh_next = b_sh_reg >> 1;
            cnt_next  = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        acc_reg  <= acc_next;
        a_sh_reg <= a_sh_next;
        b_sh_reg <= b_sh_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

// ===== rtl/rpdtp_div.sv =====
module rpdtp_div
    import rpdtp_pkg::*;
#(
    parameter int W = ACC_W
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic signed [W-1:0] num,
    input  logic [W-1:0]        den,
    output logic                done,
    output logic signed [W-1:0] quo
);

    localparam int CNT_W = $clog2(W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(W - 1);

    logic [W:0]       rem_reg, rem_next;
    logic [W-1:0]     nq_reg, nq_next;
    logic [W-1:0]     den_reg, den_next;
    logic             neg_reg, neg_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             run_reg, run_next;
    logic             done_reg, done_next;
    logic [W:0]       rem_sh;
    logic [W:0]       rem_sub;

    always_comb begin
        rem_next  = rem_reg;
        nq_next   = nq_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        rem_sh    = {rem_reg[W-1:0], nq_reg[W-1]};
        rem_sub   = rem_sh - {1'b0, den_reg};
        if (start) begin
            neg_next = num[W-1];
            nq_next  = num[W-1] ? W'(-num) : W'(num);
            den_next = den;
            rem_next = '0;
            cnt_next = '0;
            run_next = 1'b1;
        end else if (run_reg) begin
            if (!rem_sub[W]) begin
                rem_next = rem_sub;
                nq_next  = {nq_reg[W-2:0], 1'b1};
            end else begin
                rem_next = rem_sh;
                nq_next  = {nq_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        nq_reg  <= nq_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    // truncation toward zero
    assign quo  = neg_reg ? -$signed(nq_reg) : $signed(nq_reg);
    assign done = done_reg;

endmodule

// ===== rtl/rotate_project_depth_test_plotter_core.sv =====
// Plot transaction: up to 33 passes through the bit-serial multiplier plus two
// bit-serial divisions; fewer when the point falls out of view.
// Clear and read transactions: one cell store access (none for an out-of-range address).
// One transaction at a time; the next is accepted while a result waits.
// Reset: aresetn synchronous, active low; clears control and the registers
// to their defaults. Cell stores are undefined until written.
module rotate_project_depth_test_plotter_core
    import rpdtp_pkg::*;
#(
    parameter int MAX_WIDTH       = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT      = DEF_MAX_HEIGHT,
    parameter int CAMERA_DISTANCE = DEF_CAMERA_DISTANCE
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int STORE_SIZE = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW         = $clog2(STORE_SIZE);
    localparam int WV_W       = $clog2(MAX_WIDTH + 1);
    localparam int HV_W       = $clog2(MAX_HEIGHT + 1);
    localparam logic [ACC_W-1:0] ZD_OFF = ACC_W'(CAMERA_DISTANCE * (1 << DIST_SH));

    // configuration
    logic [31:0] angle_a_reg, angle_b_reg, angle_c_reg;
    logic [15:0] center_x_reg, center_y_reg, center_z_reg;
    logic [8:0]  screen_w_reg;
    logic [7:0]  screen_h_reg;
    logic        cfg_we;
    reg_idx_t    cfg_idx;

    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite;
    assign cfg_idx = reg_idx_t'(paddr[4:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            angle_a_reg  <= 32'd16384;
            angle_b_reg  <= 32'd16384;
            angle_c_reg  <= 32'd16384;
            center_x_reg <= 16'd640;
            center_y_reg <= 16'd192;
            center_z_reg <= 16'd1600;
            screen_w_reg <= 9'd80;
            screen_h_reg <= 8'd24;
        end else if (cfg_we) begin
            case (cfg_idx)
                REG_ANGLE_A:  angle_a_reg  <= pwdata;
                REG_ANGLE_B:  angle_b_reg  <= pwdata;
                REG_ANGLE_C:  angle_c_reg  <= pwdata;
                REG_CENTER_X: center_x_reg <= pwdata[15:0];
                REG_CENTER_Y: center_y_reg <= pwdata[15:0];
                REG_CENTER_Z: center_z_reg <= pwdata[15:0];
                REG_SCREEN_W: screen_w_reg <= pwdata[8:0];
                REG_SCREEN_H: screen_h_reg <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_ANGLE_A:  prdata = angle_a_reg;
            REG_ANGLE_B:  prdata = angle_b_reg;
            REG_ANGLE_C:  prdata = angle_c_reg;
            REG_CENTER_X: prdata = {16'd0, center_x_reg};
            REG_CENTER_Y: prdata = {16'd0, center_y_reg};
            REG_CENTER_Z: prdata = {16'd0, center_z_reg};
            REG_SCREEN_W: prdata = {23'd0, screen_w_reg};
            REG_SCREEN_H: prdata = {24'd0, screen_h_reg};
            default:      prdata = '0;
        endcase
    end

    // visible area
    logic [31:0]     w_full, h_full;
    logic [WV_W-1:0] w_vis;
    logic [HV_W-1:0] h_vis;

    assign w_full = (32'(screen_w_reg) > 32'(MAX_WIDTH))  ? 32'(MAX_WIDTH)  : 32'(screen_w_reg);
    assign h_full = (32'(screen_h_reg) > 32'(MAX_HEIGHT)) ? 32'(MAX_HEIGHT) : 32'(screen_h_reg);
    assign w_vis  = w_full[WV_W-1:0];
    assign h_vis  = h_full[HV_W-1:0];

    // control and datapath state
    state_t                   state_reg, state_next;
    logic [STEP_W-1:0]        step_reg, step_next;
    in_item_t                 item_reg, item_next;
    out_item_t                res_reg, res_next;
    logic                     m_valid_reg, m_valid_next;
    out_item_t                m_data_reg, m_data_next;
    logic                     div_sel_reg, div_sel_next;
    logic signed [COEF_W-1:0] sasb_reg, sasb_next, casb_reg, casb_next;
    logic signed [COEF_W-1:0] coef_reg [NUM_COEF];
    logic signed [COEF_W-1:0] coef_next [NUM_COEF];
    logic signed [ACC_W-1:0]  xx_reg, xx_next, yy_reg, yy_next, zz_reg, zz_next;
    logic signed [ACC_W-1:0]  nx_reg, nx_next, ny_reg, ny_next;
    logic signed [ACC_W-1:0]  col_reg, col_next, row_reg, row_next;
    logic signed [ACC_W-1:0]  idx_reg, idx_next, d2_reg, d2_next;

    // arithmetic units
    logic                      mul_start, mul_done;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] mul_p;
    logic                      div_start, div_done;
    logic signed [ACC_W-1:0]   div_num, div_quo;
    logic [ACC_W-1:0]          div_den;

    rpdtp_mul #(
        .A_W(MUL_A_W),
        .B_W(MUL_B_W),
        .P_W(MUL_P_W)
    ) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_p)
    );

    rpdtp_div #(
        .W(ACC_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (div_quo)
    );

    // operands
    op_t                      op;
    logic signed [15:0]       sa, ca, sb, cb, sc, cc;
    logic signed [16:0]       dx, dy, dz;
    logic signed [ACC_W-1:0]  qx, qy, qz, zd;
    logic signed [MUL_P_W-1:0] prod_sh, acc_cur, acc_new;
    logic                     zd_pos, range_ok, cell_ok, nearer;
    logic [31:0]              d2_sat, key;
    logic [31:0]              cell_ext;

    assign op = step_op(step_reg);
    assign sa = angle_a_reg[31:16];
    assign ca = angle_a_reg[15:0];
    assign sb = angle_b_reg[31:16];
    assign cb = angle_b_reg[15:0];
    assign sc = angle_c_reg[31:16];
    assign cc = angle_c_reg[15:0];
    assign dx = 17'(item_reg.point_x) - 17'($signed(center_x_reg));
    assign dy = 17'(item_reg.point_y) - 17'($signed(center_y_reg));
    assign dz = 17'(item_reg.point_z) - 17'($signed(center_z_reg));
    assign qx = xx_reg >>> FRAC_SH;
    assign qy = yy_reg >>> FRAC_SH;
    assign qz = zz_reg >>> FRAC_SH;
    assign zd = zz_reg + $signed(ZD_OFF);
    assign zd_pos = !zd[ACC_W-1] && (zd != '0);
    assign range_ok = !col_reg[ACC_W-1] && (col_reg < ACC_W'(w_vis))
                   && !row_reg[ACC_W-1] && (row_reg < ACC_W'(h_vis));
    assign cell_ext = 32'(item_reg.cell_address);
    assign cell_ok  = cell_ext < 32'(STORE_SIZE);
    assign d2_sat   = (d2_reg > $signed(ACC_W'(D2_SAT))) ? D2_SAT : d2_reg[31:0];
    assign key      = KEY_MAX - d2_sat;

    always_comb begin
        case (op.a)
            A_SA:    mul_a = MUL_A_W'(sa);
            A_CA:    mul_a = MUL_A_W'(ca);
            A_SB:    mul_a = MUL_A_W'(sb);
            A_CB:    mul_a = MUL_A_W'(cb);
            A_SASB:  mul_a = MUL_A_W'(sasb_reg);
            A_CASB:  mul_a = MUL_A_W'(casb_reg);
            A_DX:    mul_a = MUL_A_W'(dx);
            A_DY:    mul_a = MUL_A_W'(dy);
            A_DZ:    mul_a = MUL_A_W'(dz);
            A_CX:    mul_a = MUL_A_W'($signed(center_x_reg));
            A_CY:    mul_a = MUL_A_W'($signed(center_y_reg));
            A_CZ:    mul_a = MUL_A_W'($signed(center_z_reg));
            A_XX:    mul_a = MUL_A_W'(xx_reg);
            A_YY:    mul_a = MUL_A_W'(yy_reg);
            A_ROW:   mul_a = MUL_A_W'(row_reg);
            A_QX:    mul_a = MUL_A_W'(qx);
            A_QY:    mul_a = MUL_A_W'(qy);
            A_QZ:    mul_a = MUL_A_W'(qz);
            default: mul_a = '0;
        endcase
    end

    always_comb begin
        case (op.b)
            B_SB:    mul_b = MUL_B_W'(sb);
            B_CB:    mul_b = MUL_B_W'(cb);
            B_SC:    mul_b = MUL_B_W'(sc);
            B_CC:    mul_b = MUL_B_W'(cc);
            B_ONE:   mul_b = $signed(ONE_Q14);
            B_K:     mul_b = MUL_B_W'(coef_reg[op.kidx]);
            B_DIST:  mul_b = MUL_B_W'(CAMERA_DISTANCE);
            B_WIDTH: mul_b = $signed(MUL_B_W'(w_vis));
            B_QX:    mul_b = qx[MUL_B_W-1:0];
            B_QY:    mul_b = qy[MUL_B_W-1:0];
            B_QZ:    mul_b = qz[MUL_B_W-1:0];
            default: mul_b = '0;
        endcase
    end

    always_comb begin
        case (op.dst)
            DST_SASB: acc_cur = MUL_P_W'(sasb_reg);
            DST_CASB: acc_cur = MUL_P_W'(casb_reg);
            DST_K:    acc_cur = MUL_P_W'(coef_reg[op.kidx]);
            DST_XX:   acc_cur = MUL_P_W'(xx_reg);
            DST_YY:   acc_cur = MUL_P_W'(yy_reg);
            DST_ZZ:   acc_cur = MUL_P_W'(zz_reg);
            DST_NX:   acc_cur = MUL_P_W'(nx_reg);
            DST_NY:   acc_cur = MUL_P_W'(ny_reg);
            DST_IDX:  acc_cur = MUL_P_W'(idx_reg);
            DST_D2:   acc_cur = MUL_P_W'(d2_reg);
            default:  acc_cur = '0;
        endcase
        prod_sh = op.shr14 ? (mul_p >>> FRAC_SH) : mul_p;
        case (op.mode)
            MODE_SET: acc_new = prod_sh;
            MODE_ADD: acc_new = acc_cur + prod_sh;
            MODE_SUB: acc_new = acc_cur - prod_sh;
            default:  acc_new = prod_sh;
        endcase
    end

    // cell stores
    logic [7:0]    glyph_mem [STORE_SIZE];
    logic [31:0]   depth_mem [STORE_SIZE];
    logic [7:0]    glyph_rd_reg;
    logic [31:0]   depth_rd_reg;
    logic          mem_rd_en, mem_we;
    logic [AW-1:0] mem_addr;
    logic [7:0]    mem_wglyph;
    logic [31:0]   mem_wdepth;

    assign mem_addr = (item_reg.kind == KIND_PLOT) ? idx_reg[AW-1:0] : cell_ext[AW-1:0];

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            glyph_mem[mem_addr] <= mem_wglyph;
            depth_mem[mem_addr] <= mem_wdepth;
        end
        if (mem_rd_en) begin
            glyph_rd_reg <= glyph_mem[mem_addr];
            depth_rd_reg <= depth_mem[mem_addr];
        end
    end

    assign nearer = key > depth_rd_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    case (s_data.kind)
                        KIND_PLOT: state_next = ST_MUL_GO;
                        KIND_CLEAR, KIND_READ: begin
                            state_next = (32'(s_data.cell_address) < 32'(STORE_SIZE))
                                       ? ST_CELL : ST_DONE;
                        end
                        default: state_next = ST_DONE;
                    endcase
                end
            end
            ST_MUL_GO: state_next = ST_MUL_WAIT;
            ST_MUL_WAIT: begin
                if (mul_done) begin
                    if (step_reg == STEP_Z_LAST) begin
                        state_next = ST_ZCHK;
                    end else if (step_reg == STEP_NY) begin
                        state_next = ST_DIV_GO;
                    end else if (step_reg == STEP_LAST) begin
                        state_next = ST_MEM_RD;
                    end else begin
                        state_next = ST_MUL_GO;
                    end
                end
            end
            ST_ZCHK:     state_next = zd_pos ? ST_MUL_GO : ST_DONE;
            ST_DIV_GO:   state_next = ST_DIV_WAIT;
            ST_DIV_WAIT: begin
                if (div_done) begin
                    state_next = div_sel_reg ? ST_RANGE : ST_DIV_GO;
                end
            end
            ST_RANGE:   state_next = range_ok ? ST_MUL_GO : ST_DONE;
            ST_CELL:    state_next = (item_reg.kind == KIND_CLEAR) ? ST_DONE : ST_MEM_CHK;
            ST_MEM_RD:  state_next = ST_MEM_CHK;
            ST_MEM_CHK: state_next = ST_DONE;
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        step_next    = step_reg;
        item_next    = item_reg;
        res_next     = res_reg;
        div_sel_next = div_sel_reg;
        sasb_next    = sasb_reg;
        casb_next    = casb_reg;
        coef_next    = coef_reg;
        xx_next      = xx_reg;
        yy_next      = yy_reg;
        zz_next      = zz_reg;
        nx_next      = nx_reg;
        ny_next      = ny_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        idx_next     = idx_reg;
        d2_next      = d2_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        mul_start    = 1'b0;
        div_start    = 1'b0;
        div_num      = div_sel_reg ? ny_reg : nx_reg;
        div_den      = zd;
        mem_rd_en    = 1'b0;
        mem_we       = 1'b0;
        mem_wglyph   = item_reg.glyph;
        mem_wdepth   = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    item_next    = s_data;
                    step_next    = '0;
                    div_sel_next = 1'b0;
                    res_next     = '0;
                    case (s_data.kind)
                        KIND_PLOT:  res_next.read_glyph = s_data.glyph;
                        KIND_CLEAR: begin
                            res_next.hit_address = s_data.cell_address;
                            res_next.read_glyph  = s_data.glyph;
                        end
                        KIND_READ:  res_next.hit_address = s_data.cell_address;
                        default: ;
                    endcase
                end
            end
            ST_MUL_GO: mul_start = 1'b1;
            ST_MUL_WAIT: begin
                if (mul_done) begin
                    step_next = step_reg + 1'b1;
                    case (op.dst)
                        DST_SASB: sasb_next = acc_new[COEF_W-1:0];
                        DST_CASB: casb_next = acc_new[COEF_W-1:0];
                        DST_K:    coef_next[op.kidx] = acc_new[COEF_W-1:0];
                        DST_XX:   xx_next = acc_new[ACC_W-1:0];
                        DST_YY:   yy_next = acc_new[ACC_W-1:0];
                        DST_ZZ:   zz_next = acc_new[ACC_W-1:0];
                        DST_NX:   nx_next = acc_new[ACC_W-1:0];
                        DST_NY:   ny_next = acc_new[ACC_W-1:0];
                        DST_IDX: begin
                            idx_next = acc_new[ACC_W-1:0] + col_reg;
                            res_next.hit_address = idx_next[14:0];
                        end
                        DST_D2:   d2_next = acc_new[ACC_W-1:0];
                        default: ;
                    endcase
                end
            end
            ST_ZCHK: begin
                if (!zd_pos) begin
                    res_next.out_of_view = 1'b1;
                end
            end
            ST_DIV_GO: div_start = 1'b1;
            ST_DIV_WAIT: begin
                if (div_done) begin
                    if (div_sel_reg) begin
                        row_next = div_quo;
                    end else begin
                        col_next = div_quo;
                    end
                    div_sel_next = !div_sel_reg;
                end
            end
            ST_RANGE: begin
                if (!range_ok) begin
                    res_next.out_of_view = 1'b1;
                end
            end
            ST_CELL: begin
                if (item_reg.kind == KIND_CLEAR) begin
                    mem_we           = 1'b1;
                    res_next.written = 1'b1;
                end else begin
                    mem_rd_en = 1'b1;
                end
            end
            ST_MEM_RD: mem_rd_en = 1'b1;
            ST_MEM_CHK: begin
                if (item_reg.kind == KIND_PLOT) begin
                    if (nearer) begin
                        mem_we           = 1'b1;
                        mem_wdepth       = key;
                        res_next.written = 1'b1;
                    end
                end else begin
                    res_next.read_glyph = glyph_rd_reg;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            step_reg    <= '0;
            div_sel_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            step_reg    <= step_next;
            div_sel_reg <= div_sel_next;
        end
        item_reg   <= item_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
        sasb_reg   <= sasb_next;
        casb_reg   <= casb_next;
        coef_reg   <= coef_next;
        xx_reg     <= xx_next;
        yy_reg     <= yy_next;
        zz_reg     <= zz_next;
        nx_reg     <= nx_next;
        ny_reg     <= ny_next;
        col_reg    <= col_next;
        row_reg    <= row_next;
        idx_reg    <= idx_next;
        d2_reg     <= d2_next;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== rtl/rpdtp_chk.sv =====
module rpdtp_chk
    import rpdtp_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_view_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.written && m_data.out_of_view))
        else $error("off-view result marked written");

    a_view_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.out_of_view |-> m_data.hit_address == 15'd0)
        else $error("off-view result with non-zero address");

    // one transaction in work at a time
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("accepted a transaction while busy");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind rotate_project_depth_test_plotter_core rpdtp_chk u_rpdtp_chk (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
